// ===== src/csvtok_pkg.sv =====
// csvtok_pkg: shared types, codes and helpers of the csv field tokenizer
// used by the controller, the datapath and the top level
`default_nettype none

package csvtok_pkg;

    localparam int WS_DEPTH_DEF = 16;

    localparam logic [7:0] CHR_QUOTE = 8'h22;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_LF    = 8'h0A;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_UNQ    = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_QSEEN  = 3'd3,
        MODE_AFTER  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        KIND_BYTE = 3'd0,
        KIND_FEND = 3'd1,
        KIND_DROP = 3'd2,
        KIND_REND = 3'd3,
        KIND_ERR  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_BYTE,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit_flush;
        logic emit_byte;
        logic emit_tail;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic dec_flush;
        logic dec_byte;
        logic dec_tail;
        logic flush_last;
        logic has_tail;
        logic tail_last;
        logic out_free;
    } t_status;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
               (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
    endfunction

endpackage

`default_nettype wire

// ===== src/csvtok_ram.sv =====
// csvtok_ram: generic single write port, single read port ram
// read data registered, no dependencies
`default_nettype none

module csvtok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/csvtok_ctrl.sv =====
// csvtok_ctrl: sequencer that accepts a byte and walks its results
// flush bytes, the byte itself, then markers; uses csvtok_pkg
`default_nettype none

module csvtok_ctrl
    import csvtok_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_status.dec_flush) begin
                        n_state = ST_FLUSH;
                    end else if (i_status.dec_byte) begin
                        n_state = ST_BYTE;
                    end else if (i_status.dec_tail) begin
                        n_state = ST_TAIL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit_flush = 1'b1;
                    if (i_status.flush_last) begin
                        n_state = ST_BYTE;
                    end
                end
            end
            ST_BYTE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    o_cmd.last      = !i_status.has_tail;
                    n_state         = i_status.has_tail ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.emit_tail = 1'b1;
                    o_cmd.last      = i_status.tail_last;
                    if (i_status.tail_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/csvtok_dp.sv =====
// csvtok_dp: parse state, per-byte decode, whitespace buffer and output register
// uses csvtok_pkg and csvtok_ram
`default_nettype none

module csvtok_dp
    import csvtok_pkg::*;
#(
    parameter int WS_DEPTH = WS_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_status         o_status,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_eoi,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_byte,
    output logic            o_ovf,
    output logic            o_last
);

    localparam int AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam int CW = $clog2(WS_DEPTH + 1);

    // parse state
    t_mode         r_mode, n_mode;
    logic          r_fho, n_fho;
    logic          r_rhb, n_rhb;
    logic [CW-1:0] r_pc, n_pc;
    logic          r_wso, n_wso;

    // latched plan of the accepted byte
    logic [CW-1:0] r_flush_cnt;
    logic          r_flush_ovf;
    logic [7:0]    r_byte;
    logic          r_byte_ovf;
    t_kind         r_tail [3];
    logic [1:0]    r_tn;
    logic [CW-1:0] r_fidx, n_fidx;
    logic [1:0]    r_tidx;

    // output register
    logic          r_out_valid;
    t_kind         r_kind;
    logic [7:0]    r_obyte;
    logic          r_oovf;
    logic          r_olast;

    // decode
    logic          d_flush;
    logic          d_byte;
    logic          d_byte_ovf;
    logic          d_we;
    logic [1:0]    mn, en, tn;
    t_kind         m0, m1, e0, e1;
    t_kind         t0, t1, t2;
    logic          is_lf, is_q, is_c, ws;
    logic [7:0]    ram_rdata;
    logic          out_free;

    assign is_lf = (i_in_byte == CHR_LF);
    assign is_q  = (i_in_byte == CHR_QUOTE);
    assign is_c  = (i_in_byte == CHR_COMMA);
    assign ws    = is_ws(i_in_byte);

    always_comb begin
        n_mode     = r_mode;
        n_fho      = r_fho;
        n_rhb      = r_rhb;
        n_pc       = r_pc;
        n_wso      = r_wso;
        d_flush    = 1'b0;
        d_byte     = 1'b0;
        d_byte_ovf = 1'b0;
        d_we       = 1'b0;
        mn         = 2'd0;
        m0         = KIND_FEND;
        m1         = KIND_REND;
        en         = 2'd0;
        e0         = KIND_REND;
        e1         = KIND_REND;
        if (is_lf) begin
            priority if (r_mode == MODE_QUOTED) begin
                d_byte = 1'b1;
                n_fho  = 1'b1;
            end else if (r_rhb) begin
                if (r_mode != MODE_AFTER) begin
                    m0 = KIND_FEND;
                    m1 = KIND_REND;
                    mn = 2'd2;
                end else begin
                    m0 = KIND_REND;
                    mn = 2'd1;
                end
                n_mode = MODE_START;
                n_rhb  = 1'b0;
                n_fho  = 1'b0;
                n_pc   = '0;
                n_wso  = 1'b0;
            end else begin
                n_mode = MODE_START;
            end
        end else begin
            n_rhb = 1'b1;
            priority if (is_q) begin
                unique case (r_mode)
                    MODE_UNQ: begin
                        if (r_fho) begin
                            m0 = KIND_DROP;
                            mn = 2'd1;
                        end
                        n_pc   = '0;
                        n_wso  = 1'b0;
                        n_fho  = 1'b0;
                        n_mode = MODE_QUOTED;
                    end
                    MODE_QUOTED: begin
                        n_mode = MODE_QSEEN;
                    end
                    MODE_QSEEN: begin
                        d_byte = 1'b1;
                        n_fho  = 1'b1;
                        n_mode = MODE_QUOTED;
                    end
                    default: begin
                        n_fho  = 1'b0;
                        n_mode = MODE_QUOTED;
                    end
                endcase
            end else if (is_c) begin
                unique case (r_mode)
                    MODE_QUOTED: begin
                        d_byte = 1'b1;
                        n_fho  = 1'b1;
                    end
                    MODE_AFTER: begin
                        n_mode = MODE_START;
                    end
                    default: begin
                        m0     = KIND_FEND;
                        mn     = 2'd1;
                        n_fho  = 1'b0;
                        n_pc   = '0;
                        n_wso  = 1'b0;
                        n_mode = MODE_START;
                    end
                endcase
            end else begin
                unique case (r_mode)
                    MODE_START: begin
                        if (!ws) begin
                            d_byte = 1'b1;
                            n_fho  = 1'b1;
                            n_mode = MODE_UNQ;
                        end
                    end
                    MODE_UNQ: begin
                        if (ws) begin
                            if (r_pc < CW'(WS_DEPTH)) begin
                                d_we = 1'b1;
                                n_pc = r_pc + CW'(1);
                            end else begin
                                n_wso = 1'b1;
                            end
                        end else begin
                            d_flush    = (r_pc != '0);
                            d_byte     = 1'b1;
                            d_byte_ovf = r_wso;
                            n_pc       = '0;
                            n_wso      = 1'b0;
                            n_fho      = 1'b1;
                        end
                    end
                    MODE_QUOTED: begin
                        d_byte = 1'b1;
                        n_fho  = 1'b1;
                    end
                    MODE_QSEEN: begin
                        m0     = KIND_FEND;
                        mn     = 2'd1;
                        n_fho  = 1'b0;
                        n_pc   = '0;
                        n_wso  = 1'b0;
                        n_mode = MODE_AFTER;
                    end
                    default: begin
                    end
                endcase
            end
        end
        // end of input
        if (i_in_eoi) begin
            priority if (n_mode == MODE_QUOTED) begin
                e0 = KIND_ERR;
                en = 2'd1;
            end else if (n_rhb) begin
                if (n_mode != MODE_AFTER) begin
                    e0 = KIND_FEND;
                    e1 = KIND_REND;
                    en = 2'd2;
                end else begin
                    e0 = KIND_REND;
                    en = 2'd1;
                end
            end else begin
                en = 2'd0;
            end
            n_mode = MODE_START;
            n_fho  = 1'b0;
            n_rhb  = 1'b0;
            n_pc   = '0;
            n_wso  = 1'b0;
        end
    end

    // merge row-level markers of the byte and of end of input
    assign tn = mn + en;
    assign t0 = (mn != 2'd0) ? m0 : e0;
    assign t1 = (mn == 2'd2) ? m1 : ((mn == 2'd1) ? e0 : e1);
    assign t2 = (mn == 2'd2) ? e0 : e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_fho  <= 1'b0;
            r_rhb  <= 1'b0;
            r_pc   <= '0;
            r_wso  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_mode <= n_mode;
            r_fho  <= n_fho;
            r_rhb  <= n_rhb;
            r_pc   <= n_pc;
            r_wso  <= n_wso;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_flush_cnt <= r_pc;
            r_flush_ovf <= r_wso;
            r_byte      <= i_in_byte;
            r_byte_ovf  <= d_byte_ovf;
            r_tail[0]   <= t0;
            r_tail[1]   <= t1;
            r_tail[2]   <= t2;
            r_tn        <= tn;
        end
    end

    always_comb begin
        priority if (i_cmd.accept) begin
            n_fidx = '0;
        end else if (i_cmd.emit_flush) begin
            n_fidx = r_fidx + CW'(1);
        end else begin
            n_fidx = r_fidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fidx <= n_fidx;
        if (i_cmd.accept) begin
            r_tidx <= 2'd0;
        end else if (i_cmd.emit_tail) begin
            r_tidx <= r_tidx + 2'd1;
        end
    end

    csvtok_ram #(
        .WIDTH (8),
        .DEPTH (WS_DEPTH)
    ) u_ws_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && d_we),
        .i_waddr (r_pc[AW-1:0]),
        .i_wdata (i_in_byte),
        .i_raddr (n_fidx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_flush || i_cmd.emit_byte || i_cmd.emit_tail) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_flush) begin
            r_kind  <= KIND_BYTE;
            r_obyte <= ram_rdata;
            r_oovf  <= r_flush_ovf;
            r_olast <= 1'b0;
        end else if (i_cmd.emit_byte) begin
            r_kind  <= KIND_BYTE;
            r_obyte <= r_byte;
            r_oovf  <= r_byte_ovf;
            r_olast <= i_cmd.last;
        end else if (i_cmd.emit_tail) begin
            r_kind  <= r_tail[r_tidx];
            r_obyte <= 8'h00;
            r_oovf  <= 1'b0;
            r_olast <= i_cmd.last;
        end
    end

    assign o_status.dec_flush  = d_flush;
    assign o_status.dec_byte   = d_byte;
    assign o_status.dec_tail   = (tn != 2'd0);
    assign o_status.flush_last = ((r_fidx + CW'(1)) == r_flush_cnt);
    assign o_status.has_tail   = (r_tn != 2'd0);
    assign o_status.tail_last  = ((r_tidx + 2'd1) == r_tn);
    assign o_status.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_byte      = r_obyte;
    assign o_ovf       = r_oovf;
    assign o_last      = r_olast;

endmodule

`default_nettype wire

// ===== src/csv_field_tokenizer.sv =====
// csv_field_tokenizer: top level, stream ports around controller and datapath
// uses csvtok_pkg, csvtok_ctrl, csvtok_dp
//
// Streaming CSV tokenizer: one file byte per request in, a run of result
// requests out (field bytes, field end, field drop, row end, unclosed quote
// error), the last one of each run flagged on tlast. While the output is
// free, the sequencer loads one result a cycle into the output register and
// pending trailing whitespace is read back from its buffer ram one entry a
// cycle. The next byte is taken as soon as the last result of the run sits
// in the output register. A stalled output stalls the sequencer.
`default_nettype none

module csv_field_tokenizer
    import csvtok_pkg::*;
#(
    parameter int WS_DEPTH = WS_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] ws_overflow
    output logic [2:0]       m_axis_tuser,   // [2:0] kind
    output logic             m_axis_tlast    // last_of_run
);

    t_cmd       cmd;
    t_status    status;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       out_ovf;

    csvtok_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    csvtok_dp #(
        .WS_DEPTH (WS_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_byte   (s_axis_tdata),
        .i_in_eoi    (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (out_kind),
        .o_byte      (out_byte),
        .o_ovf       (out_ovf),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, out_ovf, out_byte};
    assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire

// ===== sim/csv_field_tokenizer_tb.sv =====
// csv_field_tokenizer_tb: self-checking testbench of the csv field tokenizer
// byte stream in, predicted token stream compared against the master side
// uses csvtok_pkg and csv_field_tokenizer
`default_nettype none

module csv_field_tokenizer_tb;
    import csvtok_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WS_SLOTS = WS_DEPTH_DEF;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       ovf;
        logic       last;
    } token_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;    // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] ws_overflow
    logic [2:0]  m_axis_tuser;           // [2:0] kind
    logic        m_axis_tlast;           // last_of_run

    token_t     expected_tokens [$];
    token_t     want;
    token_t     got;
    int         mismatch_count = 0;
    int         bytes_sent = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         ready_hold = 0;
    logic [7:0] file_bytes [$];

    // tokenizer state mirror
    t_mode      pmode;
    logic       field_out;
    logic       row_bytes;
    logic       ws_ovf;
    logic [7:0] ws_buf [WS_SLOTS];
    int         ws_cnt;

    csv_field_tokenizer #(
        .WS_DEPTH(WS_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial forever #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic blank(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B ||
               b == 8'h0C || b == 8'h0D;
    endfunction

    function automatic void push_token(input t_kind k, input logic [7:0] d, input logic o);
        token_t t;
        t.kind = k;
        t.data = (k == KIND_BYTE) ? d : 8'h00;
        t.ovf  = o;
        t.last = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void reset_parser();
        pmode     = MODE_START;
        field_out = 1'b0;
        row_bytes = 1'b0;
        ws_cnt    = 0;
        ws_ovf    = 1'b0;
    endfunction

    function automatic void close_field();
        push_token(KIND_FEND, 8'h00, 1'b0);
        field_out = 1'b0;
        ws_cnt    = 0;
        ws_ovf    = 1'b0;
    endfunction

    function automatic void close_row();
        if (pmode != MODE_AFTER) begin
            close_field();
        end
        push_token(KIND_REND, 8'h00, 1'b0);
        pmode     = MODE_START;
        row_bytes = 1'b0;
        field_out = 1'b0;
        ws_cnt    = 0;
        ws_ovf    = 1'b0;
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        case (pmode)
            MODE_START: begin
                if (!blank(b)) begin
                    push_token(KIND_BYTE, b, 1'b0);
                    field_out = 1'b1;
                    pmode = MODE_UNQ;
                end
            end
            MODE_UNQ: begin
                if (blank(b)) begin
                    if (ws_cnt < WS_SLOTS) begin
                        ws_buf[ws_cnt] = b;
                        ws_cnt++;
                    end else begin
                        ws_ovf = 1'b1;
                    end
                end else begin
                    for (int i = 0; i < ws_cnt; i++) begin
                        push_token(KIND_BYTE, ws_buf[i], ws_ovf);
                    end
                    push_token(KIND_BYTE, b, ws_ovf);
                    ws_cnt = 0;
                    ws_ovf = 1'b0;
                    field_out = 1'b1;
                end
            end
            MODE_QUOTED: begin
                push_token(KIND_BYTE, b, 1'b0);
                field_out = 1'b1;
            end
            MODE_QSEEN: begin
                close_field();
                pmode = MODE_AFTER;
            end
            default: ;
        endcase
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic eoi);
        int first;
        first = expected_tokens.size();
        if (b == CHR_LF) begin
            if (pmode == MODE_QUOTED) begin
                push_token(KIND_BYTE, b, 1'b0);
                field_out = 1'b1;
            end else if (row_bytes) begin
                close_row();
            end else begin
                pmode = MODE_START;
            end
        end else begin
            row_bytes = 1'b1;
            if (b == CHR_QUOTE) begin
                case (pmode)
                    MODE_UNQ: begin
                        if (field_out) begin
                            push_token(KIND_DROP, 8'h00, 1'b0);
                        end
                        ws_cnt = 0;
                        ws_ovf = 1'b0;
                        field_out = 1'b0;
                        pmode = MODE_QUOTED;
                    end
                    MODE_QUOTED: pmode = MODE_QSEEN;
                    MODE_QSEEN: begin
                        push_token(KIND_BYTE, b, 1'b0);
                        field_out = 1'b1;
                        pmode = MODE_QUOTED;
                    end
                    default: begin
                        field_out = 1'b0;
                        pmode = MODE_QUOTED;
                    end
                endcase
            end else if (b == CHR_COMMA) begin
                case (pmode)
                    MODE_QUOTED: begin
                        push_token(KIND_BYTE, b, 1'b0);
                        field_out = 1'b1;
                    end
                    MODE_AFTER: pmode = MODE_START;
                    default: begin
                        close_field();
                        pmode = MODE_START;
                    end
                endcase
            end else begin
                plain_byte(b);
            end
        end
        if (eoi) begin
            if (pmode == MODE_QUOTED) begin
                push_token(KIND_ERR, 8'h00, 1'b0);
            end else if (row_bytes) begin
                close_row();
            end
            reset_parser();
        end
        if (expected_tokens.size() > first) begin
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        end
    endfunction

    // master side: random stalls, mostly short
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_axis_tready <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {t_kind'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast};
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected request kind=%0d byte=%02h ovf=%0b last=%0b",
                         $time, got.kind, got.data, got.ovf, got.last);
                mismatch_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want) begin
                    $display("%0t: expected kind=%0d byte=%02h ovf=%0b last=%0b, got kind=%0d byte=%02h ovf=%0b last=%0b",
                             $time, want.kind, want.data, want.ovf, want.last,
                             got.kind, got.data, got.ovf, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= idle_pct) begin
            return 0;
        end
        return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tokenize_byte(b, eoi);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic eoi);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], eoi && (i == s.len() - 1));
        end
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) begin
            return 8'(8'h61 + $urandom_range(0, 25));
        end
        do b = 8'($urandom_range(0, 255));
        while (blank(b) || b == CHR_QUOTE || b == CHR_COMMA);
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 7))
            0: return 8'h09;
            1: return 8'h0B;
            2: return 8'h0C;
            3: return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void add_blanks(input int n);
        repeat (n) add_byte(pick_blank());
    endfunction

    function automatic int blank_run();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 2);
    endfunction

    function automatic void build_field();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                add_blanks($urandom_range(0, 2));
                repeat ($urandom_range(1, 3)) begin
                    repeat ($urandom_range(1, 4)) add_byte(pick_text());
                    add_blanks(blank_run());
                end
            end
            5, 6, 7: begin
                add_byte(CHR_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 5))
                        0: add_byte(CHR_COMMA);
                        1: add_byte(CHR_LF);
                        2: begin
                            add_byte(CHR_QUOTE);
                            add_byte(CHR_QUOTE);
                        end
                        3: add_byte(pick_blank());
                        default: add_byte(pick_text());
                    endcase
                end
                add_byte(CHR_QUOTE);
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        add_byte($urandom_range(0, 1) ? pick_text() : pick_blank());
                    end
                end
            end
            8: ;
            default: begin
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void build_file();
        int cut;
        file_bytes.delete();
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 5) == 0) begin
                add_byte(CHR_LF);
            end
            build_field();
            repeat ($urandom_range(0, 3)) begin
                add_byte(CHR_COMMA);
                build_field();
            end
            add_byte(CHR_LF);
        end
        if ($urandom_range(0, 1) == 0) begin
            void'(file_bytes.pop_back());
        end
        if (file_bytes.size() > 1 && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            file_bytes = file_bytes[0:cut - 1];
        end
        if (file_bytes.size() == 0) begin
            add_byte(CHR_LF);
        end
    endfunction

    task automatic test_rows_and_trimming();
        send_text("\n", 1'b0);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_text(" \n", 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("a\t", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text(",\n", 1'b0);
    endtask

    task automatic test_quotes();
        send_text("x\"q\"\"\",", 1'b0);
        send_text("\"a\"bz\"c\"\n", 1'b0);
    endtask

    task automatic test_end_of_input();
        send_text("\",\n", 1'b1);
        send_text("a", 1'b1);
        send_text("\n", 1'b1);
        send_text("\"a\" ", 1'b1);
    endtask

    task automatic test_ws_overflow();
        send_text("a", 1'b0);
        repeat (WS_SLOTS + 1) send_byte(pick_blank(), 1'b0);
        send_text("b", 1'b1);
    endtask

    task automatic test_random_files(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            case ($urandom_range(0, 3))
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 15;
                    stall_pct = 15;
                end
                2: begin
                    idle_pct = 50;
                    stall_pct = 50;
                end
                default: begin
                    idle_pct = $urandom_range(0, 80);
                    stall_pct = $urandom_range(0, 80);
                end
            endcase
            build_file();
            foreach (file_bytes[i]) begin
                send_byte(file_bytes[i], i == file_bytes.size() - 1);
            end
            if ($urandom_range(0, 4) == 0) begin
                hold_until_drained();
            end
        end
    endtask

    initial begin
        reset_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 20;
        stall_pct = 20;
        test_rows_and_trimming();
        test_quotes();
        test_end_of_input();
        test_ws_overflow();
        hold_until_drained();
        test_random_files(255);
        hold_until_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/csvtok_pkg.sv
src/csvtok_ram.sv
src/csvtok_ctrl.sv
src/csvtok_dp.sv
src/csv_field_tokenizer.sv
sim/csv_field_tokenizer_tb.sv
